### src/scalar_to_colormap_rgb_macros.svh
`ifndef SCALAR_TO_COLORMAP_RGB_MACROS_SVH
`define SCALAR_TO_COLORMAP_RGB_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define S2CM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define S2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/s2cm_pkg.sv
`default_nettype none

package s2cm_pkg;

    localparam int SAMPLE_W   = 18;
    localparam int LEVEL_W    = 17;
    localparam int CHANNELS   = 3;
    localparam int POLY_ROWS  = 5;
    localparam int POLY_TERMS = 4;
    localparam int ROW_W      = 3;

    // colormap codes as written to the map select register
    typedef enum logic [2:0] {
        MAP_NONE     = 3'd0,
        MAP_VIRIDIS  = 3'd1,
        MAP_PLASMA   = 3'd2,
        MAP_INFERNO  = 3'd3,
        MAP_MAGMA    = 3'd4,
        MAP_JET      = 3'd5,
        MAP_COOLWARM = 3'd6,
        MAP_GRAY     = 3'd7
    } map_t;

    // one result, red in the low bits
    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } rgb_t;

    // pipeline advance and the map code held at each stage
    typedef struct packed {
        logic adv;
        map_t map_s1;
        map_t map_s2;
        map_t map_s3;
        map_t map_s4;
    } stage_ctl_t;

    // polynomial coefficients in hundredths: [row][channel][degree]
    localparam int POLY_HUNDREDTHS [POLY_ROWS][CHANNELS][POLY_TERMS] = '{
        '{ '{-35, 170,  -90,  55}, '{ -5,  70,   30,   0}, '{33,  70, -160,  60} },
        '{ '{  5, 220, -130,   0}, '{-20, 120,    0,   0}, '{53,  50, -200, 100} },
        '{ '{-10, 250, -150,   0}, '{-30, 150,    0,   0}, '{10, 200, -350, 150} },
        '{ '{ -5, 200,  -80,   0}, '{-30, 130,   10,   0}, '{15, 150, -250, 150} },
        '{ '{ 23, 150,  -70,   0}, '{ 30, 120, -150,   0}, '{75, -50,  -20,   0} }
    };

    // hundredths to fixed point, rounded to nearest, ties away from zero
    function automatic longint coef_fx(input int hundredths, input int frac);
        longint mag;
        longint q;
        mag = (hundredths < 0) ? -longint'(hundredths) : longint'(hundredths);
        q   = (mag * (longint'(1) << frac) + 50) / 100;
        return (hundredths < 0) ? -q : q;
    endfunction

    // polynomial row of a map code; only meaningful for polynomial maps
    function automatic logic [ROW_W-1:0] map_row(input map_t m);
        logic [ROW_W-1:0] r;
        case (m)
            MAP_VIRIDIS:  r = 3'd0;
            MAP_PLASMA:   r = 3'd1;
            MAP_INFERNO:  r = 3'd2;
            MAP_MAGMA:    r = 3'd3;
            MAP_COOLWARM: r = 3'd4;
            default:      r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/s2cm_chan.sv
`default_nettype none

module s2cm_chan #(
    parameter int FRAC_BITS = 16,
    parameter int CH        = 0
) (
    input  wire logic                          aclk,
    input  wire s2cm_pkg::stage_ctl_t          ctl,
    input  wire logic [FRAC_BITS:0]            t_s1,
    input  wire logic [FRAC_BITS:0]            sq_s2,
    input  wire logic [FRAC_BITS:0]            cube_s3,
    input  wire logic [FRAC_BITS:0]            t_s4,
    output logic      [s2cm_pkg::LEVEL_W-1:0]  level_s5
);
    import s2cm_pkg::*;

    localparam int TW    = FRAC_BITS + 1;
    localparam int CW    = FRAC_BITS + 4;
    localparam int SW    = FRAC_BITS + 6;
    localparam int PRW   = CW + TW + 1;
    localparam int ONE_I = 1 << FRAC_BITS;

    localparam logic signed [SW-1:0] ONE_S    = SW'(ONE_I);
    localparam logic signed [SW-1:0] JET_PEAK = SW'(3 * ONE_I / 2);
    localparam logic [TW-1:0]        CENTRE   = TW'((3 - CH) * ONE_I / 4);

    // constant coefficients of this channel
    logic signed [CW-1:0] coef [POLY_ROWS][POLY_TERMS];

    for (genvar r = 0; r < POLY_ROWS; r++) begin : g_row
        for (genvar d = 0; d < POLY_TERMS; d++) begin : g_deg
            assign coef[r][d] = CW'(coef_fx(POLY_HUNDREDTHS[r][CH][d], FRAC_BITS));
        end
    end

    logic [ROW_W-1:0] row_s1, row_s2, row_s3;
    assign row_s1 = map_row(ctl.map_s1);
    assign row_s2 = map_row(ctl.map_s2);
    assign row_s3 = map_row(ctl.map_s3);

    // one product per stage, floor shifted back to the fraction point
    logic signed [PRW-1:0] prod1, prod2, prod3;
    assign prod1 = coef[row_s1][1] * $signed({1'b0, t_s1});
    assign prod2 = coef[row_s2][2] * $signed({1'b0, sq_s2});
    assign prod3 = coef[row_s3][3] * $signed({1'b0, cube_s3});

    logic signed [SW-1:0] p1_s2_next, p2_s3_next, p3_s4_next, acc_s3_next, acc_s4_next;
    logic signed [SW-1:0] p1_s2_reg, p2_s3_reg, p3_s4_reg, acc_s3_reg, acc_s4_reg;

    assign p1_s2_next  = SW'(prod1 >>> FRAC_BITS);
    assign p2_s3_next  = SW'(prod2 >>> FRAC_BITS);
    assign p3_s4_next  = SW'(prod3 >>> FRAC_BITS);
    assign acc_s3_next = SW'(coef[row_s2][0]) + p1_s2_reg;
    assign acc_s4_next = acc_s3_reg + p2_s3_reg;

    // final sum, jet ramp and map selection
    logic signed [SW-1:0] poly_sum, poly_clamp, jet_dif, jet_abs, jet_raw, jet_clamp;
    logic [LEVEL_W-1:0]   level_s5_next, level_s5_reg;

    always_comb begin
        poly_sum = acc_s4_reg + p3_s4_reg;
        if (poly_sum < 0) begin
            poly_clamp = '0;
        end else if (poly_sum > ONE_S) begin
            poly_clamp = ONE_S;
        end else begin
            poly_clamp = poly_sum;
        end

        jet_dif = SW'($signed({1'b0, t_s4})) - SW'($signed({1'b0, CENTRE}));
        jet_abs = (jet_dif < 0) ? -jet_dif : jet_dif;
        jet_raw = JET_PEAK - (jet_abs <<< 2);
        if (jet_raw < 0) begin
            jet_clamp = '0;
        end else if (jet_raw > ONE_S) begin
            jet_clamp = ONE_S;
        end else begin
            jet_clamp = jet_raw;
        end

        case (ctl.map_s4)
            MAP_VIRIDIS, MAP_PLASMA, MAP_INFERNO, MAP_MAGMA, MAP_COOLWARM: begin
                level_s5_next = LEVEL_W'(poly_clamp);
            end
            MAP_JET: begin
                level_s5_next = LEVEL_W'(jet_clamp);
            end
            MAP_GRAY: begin
                level_s5_next = LEVEL_W'(t_s4);
            end
            default: begin
                level_s5_next = LEVEL_W'(ONE_I / 2);
            end
        endcase
    end

    // stage registers, all held while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            p1_s2_reg    <= p1_s2_next;
            p2_s3_reg    <= p2_s3_next;
            acc_s3_reg   <= acc_s3_next;
            p3_s4_reg    <= p3_s4_next;
            acc_s4_reg   <= acc_s4_next;
            level_s5_reg <= level_s5_next;
        end
    end

    assign level_s5 = level_s5_reg;

endmodule

`default_nettype wire

### src/scalar_to_colormap_rgb.sv
// channel   | direction | tdata fields (low bit up)           | tuser / tlast
// s_axis    | in        | sample_value[17:0], zero pad to 24   | none
// m_axis    | out       | red_level[16:0], green_level[16:0],  | none
//           |           | blue_level[16:0], zero pad to 56     |
// cfg       | in        | cfg_wr_data = map_select[2:0]        | write on cfg_wr_en
//
// one sample per clock while the skid stage is empty; a sample reaches m_axis
// through six registers (clamp, square, cube, cube term, final sum,
// output register)
// the depth is set by the chain t -> t^2 -> t^3 -> c3*t^3, one multiply a stage
// aresetn (synchronous, active low) empties the pipeline and selects map none;
// s_axis_tready stays low while it is held
// a stalled m_axis fills a one-entry skid stage, then s_axis_tready drops
`default_nettype none
`include "scalar_to_colormap_rgb_macros.svh"

module scalar_to_colormap_rgb #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,
    // input samples
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // sample_value[17:0]
    // colors
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata    // red_level, green_level, blue_level
);
    import s2cm_pkg::*;

    localparam int TW    = FRAC_BITS + 1;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int NSTG  = 5;

    // map select register
    map_t map_select_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_select_reg <= MAP_NONE;
        end else if (cfg_wr_en) begin
            map_select_reg <= map_t'(cfg_wr_data);
        end
    end

    // pipeline advance: only a full skid stage stops it
    logic skid_v_reg;
    logic pipe_en;
    assign pipe_en       = !skid_v_reg;
    assign s_axis_tready = pipe_en && aresetn;

    // valid bits, one per stage
    logic [NSTG-1:0] v_reg, v_next;
    assign v_next = {v_reg[NSTG-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= v_next;
        end
    end

    // stage 1: clamp the sample into [0, one]
    logic signed [SAMPLE_W-1:0] sample;
    logic [TW-1:0]              t_s1_next;
    assign sample = $signed(s_axis_tdata[SAMPLE_W-1:0]);

    always_comb begin
        if (sample[SAMPLE_W-1]) begin
            t_s1_next = '0;
        end else if (int'(sample) > ONE_I) begin
            t_s1_next = TW'(ONE_I);
        end else begin
            t_s1_next = TW'($unsigned(sample));
        end
    end

    // stages 2 and 3: square and cube of t
    logic [2*TW-1:0] sq_full, cube_full;
    logic [TW-1:0]   t_s1_reg, t_s2_reg, t_s3_reg, t_s4_reg;
    logic [TW-1:0]   sq_s2_reg, cube_s3_reg;
    map_t            map_s1_reg, map_s2_reg, map_s3_reg, map_s4_reg;

    assign sq_full   = t_s1_reg * t_s1_reg;
    assign cube_full = sq_s2_reg * t_s2_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            t_s1_reg    <= t_s1_next;
            map_s1_reg  <= map_select_reg;
            t_s2_reg    <= t_s1_reg;
            sq_s2_reg   <= sq_full[FRAC_BITS +: TW];
            map_s2_reg  <= map_s1_reg;
            t_s3_reg    <= t_s2_reg;
            cube_s3_reg <= cube_full[FRAC_BITS +: TW];
            map_s3_reg  <= map_s2_reg;
            t_s4_reg    <= t_s3_reg;
            map_s4_reg  <= map_s3_reg;
        end
    end

    stage_ctl_t ctl;
    assign ctl = '{adv: pipe_en, map_s1: map_s1_reg, map_s2: map_s2_reg,
                   map_s3: map_s3_reg, map_s4: map_s4_reg};

    // per-channel polynomial, jet ramp and selection
    logic [LEVEL_W-1:0] lvl_s5 [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        s2cm_chan #(
            .FRAC_BITS (FRAC_BITS),
            .CH        (c)
        ) u_chan (
            .aclk     (aclk),
            .ctl      (ctl),
            .t_s1     (t_s1_reg),
            .sq_s2    (sq_s2_reg),
            .cube_s3  (cube_s3_reg),
            .t_s4     (t_s4_reg),
            .level_s5 (lvl_s5[c])
        );
    end

    rgb_t pipe_rgb;
    assign pipe_rgb = '{blue: lvl_s5[2], green: lvl_s5[1], red: lvl_s5[0]};

    // output register with a one-entry skid stage behind it
    logic pipe_out_v;
    logic m_valid_reg;
    rgb_t out_rgb_reg, skid_rgb_reg;

    assign pipe_out_v = v_reg[NSTG-1] && pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (m_valid_reg && !m_axis_tready) begin
            if (pipe_out_v) begin
                skid_v_reg <= 1'b1;
            end
        end else if (skid_v_reg) begin
            m_valid_reg <= 1'b1;
            skid_v_reg  <= 1'b0;
        end else begin
            m_valid_reg <= pipe_out_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_axis_tready) begin
            if (pipe_out_v) begin
                skid_rgb_reg <= pipe_rgb;
            end
        end else if (skid_v_reg) begin
            out_rgb_reg <= skid_rgb_reg;
        end else if (pipe_out_v) begin
            out_rgb_reg <= pipe_rgb;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, out_rgb_reg};

    // checks
    `S2CM_ASSERT_IMPL(a_skid_behind_out, skid_v_reg, m_valid_reg, "skid full while output empty")
    `S2CM_ASSERT_NEXT(a_last_stage_held, v_reg[NSTG-1] && skid_v_reg, v_reg[NSTG-1], "stalled item lost")
    `S2CM_ASSERT_IMPL(a_red_in_range, m_valid_reg, (FRAC_BITS > 16) || (int'(out_rgb_reg.red) <= ONE_I), "red above one")

endmodule

`default_nettype wire

### tb/sv/colormap_checker.sv
`timescale 1ns / 1ps

module colormap_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sample_value[17:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // red_level, green_level, blue_level
    output int          mismatch_count,
    output int          pending_colors
);
    import s2cm_pkg::*;

    localparam int     FRAC = 16;
    localparam longint UNIT = longint'(1) << FRAC;

    // colormap polynomials in hundredths: [viridis..coolwarm][r,g,b][degree 0..3]
    localparam int CURVE_CENTS [5][3][4] = '{
        '{ '{-35, 170,  -90,  55}, '{ -5,  70,   30,   0}, '{33,  70, -160,  60} },
        '{ '{  5, 220, -130,   0}, '{-20, 120,    0,   0}, '{53,  50, -200, 100} },
        '{ '{-10, 250, -150,   0}, '{-30, 150,    0,   0}, '{10, 200, -350, 150} },
        '{ '{ -5, 200,  -80,   0}, '{-30, 130,   10,   0}, '{15, 150, -250, 150} },
        '{ '{ 23, 150,  -70,   0}, '{ 30, 120, -150,   0}, '{75, -50,  -20,   0} }
    };

    map_t   active_map;
    rgb_t   color_queue [$];
    rgb_t   want;
    rgb_t   got;
    int     fail_total = 0;

    assign mismatch_count = fail_total;

    // hundredths to fixed point, nearest, ties away from zero
    function automatic longint cents_to_fx(input int cents);
        longint scaled;
        scaled = longint'(cents) * UNIT;
        if (scaled >= 0)
            return (scaled + 50) / 100;
        return -((50 - scaled) / 100);
    endfunction

    function automatic longint unit_clamp(input longint x);
        if (x < 0)
            return 0;
        if (x > UNIT)
            return UNIT;
        return x;
    endfunction

    // tent of height 1.5 and slope 4 around a center
    function automatic longint jet_ramp(input longint t, input longint center);
        longint span;
        span = t - center;
        if (span < 0)
            span = -span;
        return unit_clamp(3 * UNIT / 2 - 4 * span);
    endfunction

    // expected color of one sample under a map
    function automatic rgb_t colormap_levels(input map_t m, input logic [17:0] raw);
        longint powers [4];
        longint lvl [3];
        longint acc;
        int     row;
        rgb_t   res;
        powers[1] = unit_clamp(longint'($signed(raw)));
        powers[2] = (powers[1] * powers[1]) >>> FRAC;
        powers[3] = (powers[2] * powers[1]) >>> FRAC;
        powers[0] = UNIT;
        case (m)
            MAP_VIRIDIS:  row = 0;
            MAP_PLASMA:   row = 1;
            MAP_INFERNO:  row = 2;
            MAP_MAGMA:    row = 3;
            MAP_COOLWARM: row = 4;
            default:      row = -1;
        endcase
        if (row >= 0) begin
            for (int ch = 0; ch < 3; ch++) begin
                acc = cents_to_fx(CURVE_CENTS[row][ch][0]);
                for (int k = 1; k < 4; k++)
                    acc += (cents_to_fx(CURVE_CENTS[row][ch][k]) * powers[k]) >>> FRAC;
                lvl[ch] = unit_clamp(acc);
            end
        end else if (m == MAP_JET) begin
            lvl[0] = jet_ramp(powers[1], 3 * UNIT / 4);
            lvl[1] = jet_ramp(powers[1], UNIT / 2);
            lvl[2] = jet_ramp(powers[1], UNIT / 4);
        end else if (m == MAP_GRAY) begin
            lvl[0] = powers[1];
            lvl[1] = powers[1];
            lvl[2] = powers[1];
        end else begin
            lvl[0] = UNIT / 2;
            lvl[1] = UNIT / 2;
            lvl[2] = UNIT / 2;
        end
        res.red   = lvl[0][LEVEL_W-1:0];
        res.green = lvl[1][LEVEL_W-1:0];
        res.blue  = lvl[2][LEVEL_W-1:0];
        return res;
    endfunction

    // track the map register, predict on each input transfer, compare on each output one
    always @(posedge aclk) begin
        if (!aresetn) begin
            active_map = MAP_NONE;
            color_queue.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                color_queue = {color_queue, colormap_levels(active_map, s_axis_tdata[17:0])};
            if (cfg_wr_en)
                active_map = map_t'(cfg_wr_data);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[3*LEVEL_W-1:0];
                if (color_queue.size() == 0) begin
                    $display("%0t: unexpected color transfer, actual %h", $time, got);
                    fail_total++;
                end else begin
                    want = color_queue.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t: red_level expected %0d actual %0d",
                                 $time, want.red, got.red);
                        fail_total++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green_level expected %0d actual %0d",
                                 $time, want.green, got.green);
                        fail_total++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue_level expected %0d actual %0d",
                                 $time, want.blue, got.blue);
                        fail_total++;
                    end
                end
            end
        end
        pending_colors = color_queue.size();
    end

endmodule

### tb/sv/scalar_to_colormap_rgb_tb.sv
`timescale 1ns / 1ps

module scalar_to_colormap_rgb_tb;
    import s2cm_pkg::*;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_wr_data   = 3'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    int mismatch_count;
    int pending_colors;
    int sent_total = 0;
    int burst_left = 1;
    int gap_max    = 0;
    bit hold_req   = 1'b0;

    scalar_to_colormap_rgb dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    colormap_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_colors (pending_colors)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("scalar_to_colormap_rgb regression: fail");
        $finish;
    end

    // offer one sample, return at the falling edge after its transfer, or after the idle gap that ends a burst
    task automatic send_sample(input logic [17:0] value);
        int gap;
        s_axis_tdata  <= {6'd0, value};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        sent_total++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(24, 1);
            gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // stop offering and wait for every color still owed
    task automatic drain_colors();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_colors != 0);
    endtask

    task automatic write_map(input map_t m);
        drain_colors();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly in-range samples, plus negatives, overshoots and raw bit patterns
    function automatic logic [17:0] random_sample();
        case ($urandom_range(9, 0))
            0:       return 18'($urandom);
            1:       return 18'(-int'($urandom_range(131072, 1)));
            2:       return 18'($urandom_range(131071, 65537));
            3:       return $urandom_range(1, 0) ? 18'd65536 : 18'd0;
            default: return 18'($urandom_range(65536, 0));
        endcase
    endfunction

    // receiver: long hold-off on request, otherwise a changing stall mode
    initial begin
        int hold_cnt;
        int mode;
        int mode_left;
        int tick;
        hold_cnt  = 0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (mode_left == 0) begin
                mode      = $urandom_range(3, 0);
                mode_left = $urandom_range(256, 64);
            end
            mode_left--;
            if (hold_req) begin
                hold_req      = 1'b0;
                hold_cnt      = 40;
                m_axis_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(3, 0) != 0);
                    2:       m_axis_tready <= ($urandom_range(1, 0) != 0);
                    default: m_axis_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [17:0] edge_samples [9];
        map_t        other_maps [7];
        map_t        pick;
        int          len;
        edge_samples = '{18'h20000, 18'h3FFFF, 18'd0, 18'd1, 18'd32768,
                         18'd65535, 18'd65536, 18'd65537, 18'h1FFFF};
        other_maps   = '{MAP_NONE, MAP_PLASMA, MAP_INFERNO, MAP_MAGMA,
                         MAP_JET, MAP_COOLWARM, MAP_GRAY};

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: range edges under one curve, then every other map once
        write_map(MAP_VIRIDIS);
        foreach (edge_samples[i])
            send_sample(edge_samples[i]);
        foreach (other_maps[i]) begin
            write_map(other_maps[i]);
            send_sample(18'd0);
            send_sample(18'd49152);
        end

        // random phases, each under its own map
        for (int phase = 0; sent_total < 1050; phase++) begin
            pick = map_t'($urandom_range(7, 0));
            write_map(pick);
            case ($urandom_range(2, 0))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 8;
            endcase
            len = $urandom_range(120, 40);
            // back-pressure run: receiver holds off while samples keep coming
            if (phase == 3) begin
                gap_max  = 0;
                hold_req = 1'b1;
            end
            for (int i = 0; i < len; i++) begin
                send_sample(random_sample());
                if (phase == 5 && i == len / 2)
                    drain_colors();
            end
        end

        drain_colors();
        repeat (12) @(negedge aclk);
        if (mismatch_count == 0 && pending_colors == 0)
            $display("scalar_to_colormap_rgb regression: pass");
        else
            $display("scalar_to_colormap_rgb regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/s2cm_pkg.sv
src/s2cm_chan.sv
src/scalar_to_colormap_rgb.sv
tb/sv/colormap_checker.sv
tb/sv/scalar_to_colormap_rgb_tb.sv
